// File: rtl/dls_pkg.sv
// ----------------------------------------------------------------------------
// dls_pkg
// Shared widths, command and register codes and record types of the
// list scheduler.
// ----------------------------------------------------------------------------
package dls_pkg;

    localparam int unsigned CMD_W      = 2;
    localparam int unsigned JOB_W      = 6;
    localparam int unsigned PROC_W     = 4;
    localparam int unsigned DUR_W      = 8;
    localparam int unsigned TICK_W     = 13;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 6;

    localparam logic [TICK_W-1:0] TICK_MAX = 13'd8191;

    localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DUR   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_JOB_COUNT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_COUNT = 4'd1;

    typedef struct packed {
        logic [JOB_W-1:0]  job_id_res;
        logic [PROC_W-1:0] processor;
        logic [TICK_W-1:0] start_time;
        logic              cycle_error;
    } rec_t;

    typedef struct packed {
        logic push;
        logic finish;
    } out_ctrl_t;

endpackage

// File: rtl/dls_if.sv
// ----------------------------------------------------------------------------
// dls_if
// Request, result and configuration channels of the list scheduler.
// ----------------------------------------------------------------------------
interface dls_job_if;
    logic                        valid;
    logic                        ready;
    logic [dls_pkg::CMD_W-1:0]   cmd;
    logic [dls_pkg::JOB_W-1:0]   job_id;
    logic [dls_pkg::JOB_W-1:0]   child_job;
    logic [dls_pkg::DUR_W-1:0]   duration;

    modport source (output valid, cmd, job_id, child_job, duration, input ready);
    modport sink   (input valid, cmd, job_id, child_job, duration, output ready);
endinterface

interface dls_res_if;
    logic                        valid;
    logic                        ready;
    logic [dls_pkg::JOB_W-1:0]   job_id_res;
    logic [dls_pkg::PROC_W-1:0]  processor;
    logic [dls_pkg::TICK_W-1:0]  start_time;
    logic                        cycle_error;
    logic                        last;

    modport source (output valid, job_id_res, processor, start_time, cycle_error, last,
                    input ready);
    modport sink   (input valid, job_id_res, processor, start_time, cycle_error, last,
                    output ready);
endinterface

interface dls_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dls_pkg::CFG_IDX_W-1:0]   index;
    logic [dls_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/dls_ram.sv
// ----------------------------------------------------------------------------
// dls_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module dls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/dls_out.sv
// ----------------------------------------------------------------------------
// dls_out
// Result buffer: holds one record back so the final one carries last.
// ----------------------------------------------------------------------------
module dls_out (
    input  logic               clk,
    input  logic               rst_n,
    input  dls_pkg::out_ctrl_t ctrl,
    input  dls_pkg::rec_t      rec,
    output logic               free,
    dls_res_if.source          res
);

    dls_pkg::rec_t pend_reg, pend_next;
    dls_pkg::rec_t out_reg, out_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic          last_reg, last_next;

    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        last_next       = last_reg;
        if (res.valid && res.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.push)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                last_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = rec;
            pend_valid_next = 1'b1;
        end
        else if (ctrl.finish)
        begin
            out_next        = pend_reg;
            last_next       = 1'b1;
            out_valid_next  = pend_valid_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign free            = !out_valid_reg;
    assign res.valid       = out_valid_reg;
    assign res.job_id_res  = out_reg.job_id_res;
    assign res.processor   = out_reg.processor;
    assign res.start_time  = out_reg.start_time;
    assign res.cycle_error = out_reg.cycle_error;
    assign res.last        = last_reg;

endmodule

// File: rtl/dls_seq.sv
// ----------------------------------------------------------------------------
// dls_seq
// Sequencer: loads edges and durations, counts links, then steps ticks, one
// job or processor per cycle via a shared compare/count unit; res stalls it.
// ----------------------------------------------------------------------------
module dls_seq #(
    parameter int MAX_JOBS      = 32,
    parameter int MAX_PROCS     = 8,
    parameter int DURATION_BITS = 8,
    parameter int JW            = $clog2(MAX_JOBS),
    parameter int PIW           = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    dls_job_if.sink            job_ch,
    input  logic [JW-1:0]      n_m1,
    input  logic [PIW-1:0]     p_m1,
    input  logic               out_free,
    output dls_pkg::out_ctrl_t ctrl,
    output dls_pkg::rec_t      rec
);

    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int DW = DURATION_BITS;
    localparam int NW = dls_pkg::JOB_W + 1;

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_EDGE_WR = 16'h0002,
        S_CNT_RD  = 16'h0004,
        S_CNT_COL = 16'h0008,
        S_TICK    = 16'h0010,
        S_QUEUE   = 16'h0020,
        S_PSEL    = 16'h0040,
        S_FIND    = 16'h0080,
        S_DUR     = 16'h0100,
        S_ASSIGN  = 16'h0200,
        S_IDLECHK = 16'h0400,
        S_DEC     = 16'h0800,
        S_REL_RD  = 16'h1000,
        S_REL_COL = 16'h2000,
        S_ERR     = 16'h4000,
        S_FIN     = 16'h8000
    } state_t;

    state_t                     state_reg, state_next;
    logic [JW-1:0]              i_reg, i_next;
    logic [JW-1:0]              j_reg, j_next;
    logic [PIW-1:0]             pi_reg, pi_next;
    logic [JW-1:0]              best_reg, best_next;
    logic [2*CW-1:0]            best_key_reg, best_key_next;
    logic                       best_ok_reg, best_ok_next;
    logic [JW-1:0]              ejob_reg, ejob_next;
    logic [JW-1:0]              echild_reg, echild_next;
    logic [JW-1:0]              rel_reg, rel_next;
    logic                       row_vld_reg, row_vld_next;
    logic [MAX_JOBS-1:0]        row_ok_reg, row_ok_next;
    logic [CW-1:0]              pl_reg [MAX_JOBS];
    logic [CW-1:0]              pl_next [MAX_JOBS];
    logic [CW-1:0]              ct_reg [MAX_JOBS];
    logic [CW-1:0]              ct_next [MAX_JOBS];
    logic [CW-1:0]              sq_reg [MAX_JOBS];
    logic [CW-1:0]              sq_next [MAX_JOBS];
    logic [MAX_JOBS-1:0]        queued_reg, queued_next;
    logic [MAX_JOBS-1:0]        started_reg, started_next;
    logic [MAX_JOBS-1:0]        done_reg, done_next;
    logic [DW-1:0]              rem_reg [MAX_PROCS];
    logic [DW-1:0]              rem_next [MAX_PROCS];
    logic [JW-1:0]              pjob_reg [MAX_PROCS];
    logic [JW-1:0]              pjob_next [MAX_PROCS];
    logic [CW-1:0]              rlen_reg, rlen_next;
    logic [CW-1:0]              sctr_reg, sctr_next;
    logic [dls_pkg::TICK_W-1:0] tick_reg, tick_next;

    logic                edge_we, edge_re, dur_we, dur_re;
    logic [JW-1:0]       edge_waddr, edge_raddr, dur_waddr, dur_raddr;
    logic [MAX_JOBS-1:0] edge_wdata, edge_rdata, row;
    logic [DW-1:0]       dur_wdata, dur_rdata;

    logic          accept, job_ok, child_ok, j_last, pi_last, all_done, idle;
    logic [JW-1:0] jidx, cidx;

    dls_ram #(.WIDTH(MAX_JOBS), .DEPTH(MAX_JOBS)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    dls_ram #(.WIDTH(DW), .DEPTH(MAX_JOBS)) u_dur_ram (
        .clk   (clk),
        .we    (dur_we),
        .waddr (dur_waddr),
        .wdata (dur_wdata),
        .re    (dur_re),
        .raddr (dur_raddr),
        .rdata (dur_rdata)
    );

    assign job_ch.ready = (state_reg == S_IDLE);
    assign accept       = job_ch.valid && job_ch.ready;
    assign job_ok       = (job_ch.job_id != '0) && (NW'(job_ch.job_id) <= NW'(MAX_JOBS));
    assign child_ok     = (job_ch.child_job != '0)
                          && (NW'(job_ch.child_job) <= NW'(MAX_JOBS));
    assign jidx         = JW'(job_ch.job_id - dls_pkg::JOB_W'(1));
    assign cidx         = JW'(job_ch.child_job - dls_pkg::JOB_W'(1));
    assign row          = row_vld_reg ? edge_rdata : '0;
    assign j_last       = (j_reg == n_m1);
    assign pi_last      = (pi_reg == p_m1);

    always_comb
    begin
        all_done = 1'b1;
        for (int k = 0; k < MAX_JOBS; k++)
        begin
            if (!done_reg[k] && (JW'(k) <= n_m1))
            begin
                all_done = 1'b0;
            end
        end
        idle = 1'b1;
        for (int k = 0; k < MAX_PROCS; k++)
        begin
            if (rem_reg[k] != '0)
            begin
                idle = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        pi_next       = pi_reg;
        best_next     = best_reg;
        best_key_next = best_key_reg;
        best_ok_next  = best_ok_reg;
        ejob_next     = ejob_reg;
        echild_next   = echild_reg;
        rel_next      = rel_reg;
        row_vld_next  = row_vld_reg;
        row_ok_next   = row_ok_reg;
        pl_next       = pl_reg;
        ct_next       = ct_reg;
        sq_next       = sq_reg;
        queued_next   = queued_reg;
        started_next  = started_reg;
        done_next     = done_reg;
        rem_next      = rem_reg;
        pjob_next     = pjob_reg;
        rlen_next     = rlen_reg;
        sctr_next     = sctr_reg;
        tick_next     = tick_reg;
        edge_we       = 1'b0;
        edge_re       = 1'b0;
        edge_waddr    = ejob_reg;
        edge_raddr    = i_reg;
        edge_wdata    = row | (MAX_JOBS'(1) << echild_reg);
        dur_we        = 1'b0;
        dur_re        = 1'b0;
        dur_waddr     = jidx;
        dur_raddr     = best_reg;
        dur_wdata     = DW'(job_ch.duration);
        ctrl          = '0;
        rec           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority case (job_ch.cmd)
                        dls_pkg::CMD_EDGE:
                        begin
                            if (job_ok && child_ok)
                            begin
                                edge_re      = 1'b1;
                                edge_raddr   = jidx;
                                row_vld_next = row_ok_reg[jidx];
                                ejob_next    = jidx;
                                echild_next  = cidx;
                                state_next   = S_EDGE_WR;
                            end
                        end
                        dls_pkg::CMD_DUR:
                        begin
                            dur_we = job_ok;
                        end
                        dls_pkg::CMD_START:
                        begin
                            for (int k = 0; k < MAX_JOBS; k++)
                            begin
                                pl_next[k] = '0;
                                ct_next[k] = '0;
                            end
                            for (int k = 0; k < MAX_PROCS; k++)
                            begin
                                rem_next[k] = '0;
                            end
                            queued_next  = '0;
                            started_next = '0;
                            done_next    = '0;
                            rlen_next    = '0;
                            sctr_next    = '0;
                            tick_next    = '0;
                            i_next       = '0;
                            state_next   = S_CNT_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EDGE_WR:
            begin
                edge_we               = 1'b1;
                row_ok_next[ejob_reg] = 1'b1;
                state_next            = S_IDLE;
            end
            S_CNT_RD:
            begin
                edge_re      = 1'b1;
                row_vld_next = row_ok_reg[i_reg];
                j_next       = '0;
                state_next   = S_CNT_COL;
            end
            S_CNT_COL:
            begin
                if (row[j_reg])
                begin
                    ct_next[i_reg] = ct_reg[i_reg] + CW'(1);
                    pl_next[j_reg] = pl_reg[j_reg] + CW'(1);
                end
                if (j_last)
                begin
                    if (i_reg == n_m1)
                    begin
                        state_next = S_TICK;
                    end
                    else
                    begin
                        i_next     = i_reg + JW'(1);
                        state_next = S_CNT_RD;
                    end
                end
                else
                begin
                    j_next = j_reg + JW'(1);
                end
            end
            S_TICK:
            begin
                j_next     = '0;
                state_next = all_done ? S_FIN : S_QUEUE;
            end
            S_QUEUE:
            begin
                if (!queued_reg[j_reg] && (pl_reg[j_reg] == '0))
                begin
                    queued_next[j_reg] = 1'b1;
                    sq_next[j_reg]     = sctr_reg;
                    sctr_next          = sctr_reg + CW'(1);
                    rlen_next          = rlen_reg + CW'(1);
                end
                if (j_last)
                begin
                    pi_next    = '0;
                    state_next = S_PSEL;
                end
                else
                begin
                    j_next = j_reg + JW'(1);
                end
            end
            S_PSEL:
            begin
                if (rlen_reg == '0)
                begin
                    state_next = S_IDLECHK;
                end
                else if (rem_reg[pi_reg] == '0)
                begin
                    j_next       = '0;
                    best_ok_next = 1'b0;
                    state_next   = S_FIND;
                end
                else if (pi_last)
                begin
                    state_next = S_IDLECHK;
                end
                else
                begin
                    pi_next = pi_reg + PIW'(1);
                end
            end
            S_FIND:
            begin
                if (queued_reg[j_reg] && !started_reg[j_reg]
                    && (!best_ok_reg || ({ct_reg[j_reg], sq_reg[j_reg]} > best_key_reg)))
                begin
                    best_next     = j_reg;
                    best_key_next = {ct_reg[j_reg], sq_reg[j_reg]};
                    best_ok_next  = 1'b1;
                end
                if (j_last)
                begin
                    state_next = S_DUR;
                end
                else
                begin
                    j_next = j_reg + JW'(1);
                end
            end
            S_DUR:
            begin
                dur_re     = 1'b1;
                state_next = S_ASSIGN;
            end
            S_ASSIGN:
            begin
                if (out_free)
                begin
                    rem_next[pi_reg]       = (dur_rdata == '0) ? DW'(1) : dur_rdata;
                    pjob_next[pi_reg]      = best_reg;
                    started_next[best_reg] = 1'b1;
                    rlen_next              = rlen_reg - CW'(1);
                    ctrl.push              = 1'b1;
                    rec.job_id_res         = dls_pkg::JOB_W'(best_reg) + dls_pkg::JOB_W'(1);
                    rec.processor          = dls_pkg::PROC_W'(pi_reg) + dls_pkg::PROC_W'(1);
                    rec.start_time         = tick_reg;
                    if (pi_last)
                    begin
                        state_next = S_IDLECHK;
                    end
                    else
                    begin
                        pi_next    = pi_reg + PIW'(1);
                        state_next = S_PSEL;
                    end
                end
            end
            S_IDLECHK:
            begin
                if ((rlen_reg == '0) && idle)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    if (tick_reg != dls_pkg::TICK_MAX)
                    begin
                        tick_next = tick_reg + dls_pkg::TICK_W'(1);
                    end
                    pi_next    = '0;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if ((rem_reg[pi_reg] != '0) && (rem_reg[pi_reg] == DW'(1)))
                begin
                    rem_next[pi_reg]           = '0;
                    done_next[pjob_reg[pi_reg]] = 1'b1;
                    rel_next                   = pjob_reg[pi_reg];
                    state_next                 = S_REL_RD;
                end
                else
                begin
                    if (rem_reg[pi_reg] != '0)
                    begin
                        rem_next[pi_reg] = rem_reg[pi_reg] - DW'(1);
                    end
                    if (pi_last)
                    begin
                        state_next = S_TICK;
                    end
                    else
                    begin
                        pi_next = pi_reg + PIW'(1);
                    end
                end
            end
            S_REL_RD:
            begin
                edge_re      = 1'b1;
                edge_raddr   = rel_reg;
                row_vld_next = row_ok_reg[rel_reg];
                j_next       = '0;
                state_next   = S_REL_COL;
            end
            S_REL_COL:
            begin
                if (row[j_reg] && (pl_reg[j_reg] != '0))
                begin
                    pl_next[j_reg] = pl_reg[j_reg] - CW'(1);
                end
                if (j_last)
                begin
                    if (pi_last)
                    begin
                        state_next = S_TICK;
                    end
                    else
                    begin
                        pi_next    = pi_reg + PIW'(1);
                        state_next = S_DEC;
                    end
                end
                else
                begin
                    j_next = j_reg + JW'(1);
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    ctrl.push       = 1'b1;
                    rec.start_time  = tick_reg;
                    rec.cycle_error = 1'b1;
                    state_next      = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            row_ok_reg  <= '0;
            queued_reg  <= '0;
            started_reg <= '0;
            done_reg    <= '0;
            rlen_reg    <= '0;
            sctr_reg    <= '0;
            tick_reg    <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            pi_reg      <= '0;
            best_ok_reg <= 1'b0;
            row_vld_reg <= 1'b0;
            for (int k = 0; k < MAX_JOBS; k++)
            begin
                pl_reg[k] <= '0;
                ct_reg[k] <= '0;
            end
            for (int k = 0; k < MAX_PROCS; k++)
            begin
                rem_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            row_ok_reg  <= row_ok_next;
            queued_reg  <= queued_next;
            started_reg <= started_next;
            done_reg    <= done_next;
            rlen_reg    <= rlen_next;
            sctr_reg    <= sctr_next;
            tick_reg    <= tick_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            pi_reg      <= pi_next;
            best_ok_reg <= best_ok_next;
            row_vld_reg <= row_vld_next;
            pl_reg      <= pl_next;
            ct_reg      <= ct_next;
            rem_reg     <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_key_reg <= best_key_next;
        ejob_reg     <= ejob_next;
        echild_reg   <= echild_next;
        rel_reg      <= rel_next;
        sq_reg       <= sq_next;
        pjob_reg     <= pjob_next;
    end

endmodule

// File: rtl/dag_list_scheduler_top.sv
// ----------------------------------------------------------------------------
// dag_list_scheduler_top
// List scheduler for a job dependency graph on a fixed processor count.
// ----------------------------------------------------------------------------
// Usage:
//   job_ch takes requests: load edge, load duration and start.
//   job_ch.ready is high only while the sequencer is idle.
//   A start builds link counts for n jobs, then per tick queues newly
//   ready jobs, passes over busy processors, looks up the list head for
//   each assignment, counts down the processors and releases the
//   children of each finishing job. All of this runs in the single
//   sequencer through its one compare/count unit.
//   res_ch carries one record per assignment, then an error record if the
//   graph deadlocks; last marks the final record of the run.
//   Records are held one behind, so the first appears after the second is
//   made or the run ends. A stalled res_ch holds the sequencer.
//   cfg writes job_count (index 0) and processor_count (index 1); always
//   ready, write only while idle.
//   Reset clears loaded edges, the run state and sets both registers to 1.
// ----------------------------------------------------------------------------
module dag_list_scheduler_top #(
    parameter int MAX_JOBS      = 32,
    parameter int MAX_PROCS     = 8,
    parameter int DURATION_BITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    dls_job_if.sink   job_ch,
    dls_res_if.source res_ch,
    dls_cfg_if.sink   cfg
);

    localparam int JW  = $clog2(MAX_JOBS);
    localparam int PIW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int NW  = dls_pkg::JOB_W + 1;

    logic [dls_pkg::JOB_W-1:0]  job_count_reg, job_count_next;
    logic [dls_pkg::PROC_W-1:0] proc_count_reg, proc_count_next;
    logic [NW-1:0]              n_val, p_val;
    logic [JW-1:0]              n_m1;
    logic [PIW-1:0]             p_m1;
    logic                       out_free;
    dls_pkg::out_ctrl_t         ctrl;
    dls_pkg::rec_t              rec;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        job_count_next  = job_count_reg;
        proc_count_next = proc_count_reg;
        if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == dls_pkg::REG_JOB_COUNT)
            begin
                job_count_next = dls_pkg::JOB_W'(cfg.data);
            end
            else if (cfg.index == dls_pkg::REG_PROC_COUNT)
            begin
                proc_count_next = dls_pkg::PROC_W'(cfg.data);
            end
        end
    end

    always_comb
    begin
        if (job_count_reg == '0)
        begin
            n_val = NW'(1);
        end
        else if (NW'(job_count_reg) > NW'(MAX_JOBS))
        begin
            n_val = NW'(MAX_JOBS);
        end
        else
        begin
            n_val = NW'(job_count_reg);
        end
        if (proc_count_reg == '0)
        begin
            p_val = NW'(1);
        end
        else if (NW'(proc_count_reg) > NW'(MAX_PROCS))
        begin
            p_val = NW'(MAX_PROCS);
        end
        else
        begin
            p_val = NW'(proc_count_reg);
        end
        if (p_val > n_val)
        begin
            p_val = n_val;
        end
    end

    assign n_m1 = JW'(n_val - NW'(1));
    assign p_m1 = PIW'(p_val - NW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_count_reg  <= dls_pkg::JOB_W'(1);
            proc_count_reg <= dls_pkg::PROC_W'(1);
        end
        else
        begin
            job_count_reg  <= job_count_next;
            proc_count_reg <= proc_count_next;
        end
    end

    dls_seq #(
        .MAX_JOBS      (MAX_JOBS),
        .MAX_PROCS     (MAX_PROCS),
        .DURATION_BITS (DURATION_BITS),
        .JW            (JW),
        .PIW           (PIW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_ch   (job_ch),
        .n_m1     (n_m1),
        .p_m1     (p_m1),
        .out_free (out_free),
        .ctrl     (ctrl),
        .rec      (rec)
    );

    dls_out u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .rec   (rec),
        .free  (out_free),
        .res   (res_ch)
    );

endmodule
